### src/bdfc_pkg.sv
// bdfc_pkg: shared constants for the delayed fir convolver
// command codes, configuration register indexes, widths and reset values
// no dependencies
package bdfc_pkg;

  // command field
  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_AUDIO = 2'd2;

  // configuration registers
  localparam int BLK_LOG2_W = 4;
  localparam int TRIM_W     = 15;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LOG2 = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM       = 1'd1;

  localparam logic [BLK_LOG2_W-1:0] BLK_LOG2_RESET = 4'd7;
  localparam logic [TRIM_W-1:0]     TRIM_RESET     = 15'd328;

endpackage

### src/block_delayed_fir_convolver.sv
// Fir convolver on one shared multiply-accumulate unit (one tap per cycle); needs bdfc_pkg,
// HISTORY_DEPTH and MAX_TAPS powers of two. An audio word stalls the input while its kept taps
// are multiplied and the result is formed; the next word is taken once the result is registered.
// Clear and load words do not stall the input. A trim_threshold write rescans the taps, with
// the input stalled until the rescan ends. A waiting result holds only the last step.
// Sync reset; unwritten history reads zero via a fill mark.
module block_delayed_fir_convolver #(
  parameter int MAX_TAPS       = 1024,
  parameter int MAX_BLOCK_LOG2 = 9,
  parameter int HISTORY_DEPTH  = 2048,
  parameter int SAMPLE_WIDTH   = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bdfc_pkg::CMD_W-1:0]        command,
  input  logic signed [SAMPLE_WIDTH-1:0]    data_value,
  // output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]    out_sample,
  output logic                              saturated,
  // configuration port
  input  logic                              cfg_write,
  input  logic [bdfc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bdfc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int TA_W   = $clog2(MAX_TAPS);
  localparam int TC_W   = $clog2(MAX_TAPS + 1);
  localparam int HA_W   = $clog2(HISTORY_DEPTH);
  localparam int DLY_W  = HA_W + 16;
  localparam int PROD_W = 2 * SAMPLE_WIDTH;
  localparam int ACC_W  = PROD_W + TA_W + 2;
  localparam int FRAC   = SAMPLE_WIDTH - 1;
  localparam int CMP_W  = SAMPLE_WIDTH + bdfc_pkg::TRIM_W;

  localparam logic [ACC_W-1:0] RND_BIAS = ACC_W'(1) << (SAMPLE_WIDTH - 2);
  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO =
    {{(ACC_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RESCAN = 2'd1;
  localparam logic [1:0] ST_MAC    = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  // tap magnitude at or above threshold
  function automatic logic keep_tap(input logic signed [SAMPLE_WIDTH-1:0] v,
                                    input logic [bdfc_pkg::TRIM_W-1:0] thr);
    logic [SAMPLE_WIDTH:0]   ext;
    logic [SAMPLE_WIDTH-1:0] mag;
    ext = {v[SAMPLE_WIDTH-1], v};
    mag = v[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-ext) : SAMPLE_WIDTH'(ext);
    return CMP_W'(mag) >= CMP_W'(thr);
  endfunction

  // memories
  logic signed [SAMPLE_WIDTH-1:0] tap_mem  [MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] hist_mem [HISTORY_DEPTH];

  // registers
  logic [1:0]                      state;
  logic [bdfc_pkg::BLK_LOG2_W-1:0] blk_log2;
  logic [bdfc_pkg::TRIM_W-1:0]     trim;
  logic [TC_W-1:0]                 tap_count;
  logic [TC_W-1:0]                 kept;
  logic [HA_W-1:0]                 write_pos;
  logic                            wrapped;
  logic [TC_W-1:0]                 scan_idx;
  logic                            sc_valid;
  logic [TC_W-1:0]                 sc_idx;
  logic [TC_W-1:0]                 k;
  logic [HA_W-1:0]                 rptr;
  logic [HA_W-1:0]                 cur_pos;
  logic                            s1_valid;
  logic                            s1_ok;
  logic                            p_valid;
  logic signed [PROD_W-1:0]        prod;
  logic signed [ACC_W-1:0]         acc;
  logic signed [SAMPLE_WIDTH-1:0]  tap_rdata;
  logic signed [SAMPLE_WIDTH-1:0]  hist_rdata;

  // combinational
  logic                            accept;
  logic                            trim_write;
  logic [TA_W-1:0]                 tap_raddr;
  logic                            tap_we;
  logic                            hist_we;
  logic [bdfc_pkg::BLK_LOG2_W-1:0] lg_eff;
  logic [DLY_W-1:0]                delay_full;
  logic signed [SAMPLE_WIDTH-1:0]  hist_op;
  logic signed [ACC_W-1:0]         biased;
  logic signed [ACC_W-1:0]         shifted;
  logic signed [SAMPLE_WIDTH-1:0]  res_sample;
  logic                            res_sat;
  logic                            issue;

  assign trim_write = cfg_write && (cfg_index == bdfc_pkg::REG_TRIM);
  assign in_stall   = (state != ST_IDLE) || trim_write;
  assign accept     = in_valid && !in_stall;
  assign tap_we     = accept && (command == bdfc_pkg::CMD_LOAD) &&
                      (tap_count < TC_W'(MAX_TAPS));
  assign hist_we    = accept && (command == bdfc_pkg::CMD_AUDIO);
  assign tap_raddr  = (state == ST_RESCAN) ? scan_idx[TA_W-1:0] : k[TA_W-1:0];
  assign issue      = (state == ST_MAC) && (k < kept);

  // effective output delay
  assign lg_eff = (blk_log2 > bdfc_pkg::BLK_LOG2_W'(MAX_BLOCK_LOG2)) ?
                  bdfc_pkg::BLK_LOG2_W'(MAX_BLOCK_LOG2) : blk_log2;
  assign delay_full = DLY_W'(1) << lg_eff;

  // history samples never written since clear read as zero
  assign hist_op = s1_ok ? hist_rdata : '0;

  // round half up and saturate
  always_comb begin
    biased  = acc + $signed(RND_BIAS);
    shifted = biased >>> FRAC;
    res_sat = 1'b0;
    res_sample = shifted[SAMPLE_WIDTH-1:0];
    if (shifted > SAT_HI) begin
      res_sample = SAT_HI[SAMPLE_WIDTH-1:0];
      res_sat    = 1'b1;
    end else if (shifted < SAT_LO) begin
      res_sample = SAT_LO[SAMPLE_WIDTH-1:0];
      res_sat    = 1'b1;
    end
  end

  // tap store
  always_ff @(posedge clk) begin
    if (tap_we) begin
      tap_mem[tap_count[TA_W-1:0]] <= data_value;
    end
    tap_rdata <= tap_mem[tap_raddr];
  end

  // history ring
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[write_pos] <= data_value;
    end
    hist_rdata <= hist_mem[rptr];
  end

  // multiply stage and accumulator datapath
  always_ff @(posedge clk) begin
    prod <= tap_rdata * hist_op;
    if (hist_we) begin
      acc <= '0;
    end else if (p_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      blk_log2  <= bdfc_pkg::BLK_LOG2_RESET;
      trim      <= bdfc_pkg::TRIM_RESET;
      tap_count <= '0;
      kept      <= '0;
      write_pos <= '0;
      wrapped   <= 1'b0;
      scan_idx  <= '0;
      sc_valid  <= 1'b0;
      sc_idx    <= '0;
      k         <= '0;
      rptr      <= '0;
      cur_pos   <= '0;
      s1_valid  <= 1'b0;
      s1_ok     <= 1'b0;
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // output register drains; the finish step reloads it on its own
      if (out_valid && !out_stall && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end

      // pipeline valids of the mac unit
      s1_valid <= issue;
      s1_ok    <= wrapped || (rptr <= cur_pos);
      p_valid  <= s1_valid;

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (command)
              bdfc_pkg::CMD_CLEAR: begin
                tap_count <= '0;
                kept      <= '0;
                write_pos <= '0;
                wrapped   <= 1'b0;
              end
              bdfc_pkg::CMD_LOAD: begin
                if (tap_count < TC_W'(MAX_TAPS)) begin
                  if (keep_tap(data_value, trim)) begin
                    kept <= tap_count + 1'b1;
                  end
                  tap_count <= tap_count + 1'b1;
                end
              end
              bdfc_pkg::CMD_AUDIO: begin
                write_pos <= write_pos + 1'b1;
                if (write_pos == HA_W'(HISTORY_DEPTH - 1)) begin
                  wrapped <= 1'b1;
                end
                cur_pos <= write_pos;
                rptr    <= write_pos - delay_full[HA_W-1:0];
                k       <= '0;
                state   <= ST_MAC;
              end
              default: begin
              end
            endcase
          end
        end

        ST_RESCAN: begin
          if (sc_valid && keep_tap(tap_rdata, trim)) begin
            kept <= sc_idx + 1'b1;
          end
          if (scan_idx < tap_count) begin
            sc_valid <= 1'b1;
            sc_idx   <= scan_idx;
            scan_idx <= scan_idx + 1'b1;
          end else begin
            sc_valid <= 1'b0;
            if (!sc_valid) begin
              state <= ST_IDLE;
            end
          end
        end

        ST_MAC: begin
          if (issue) begin
            k    <= k + 1'b1;
            rptr <= rptr - 1'b1;
          end else if (!s1_valid && !p_valid) begin
            state <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_sample <= res_sample;
            saturated  <= res_sat;
            out_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase

      // configuration writes; a threshold write restarts the rescan
      if (cfg_write) begin
        unique case (cfg_index)
          bdfc_pkg::REG_BLOCK_LOG2: begin
            blk_log2 <= cfg_data[bdfc_pkg::BLK_LOG2_W-1:0];
          end
          bdfc_pkg::REG_TRIM: begin
            trim     <= cfg_data[bdfc_pkg::TRIM_W-1:0];
            kept     <= '0;
            scan_idx <= '0;
            sc_valid <= 1'b0;
            state    <= ST_RESCAN;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule
